/* rtl/command_line_framer_queue_core_assert.svh */
// assertion macros used by the checker of the command line framer queue
`ifndef COMMAND_LINE_FRAMER_QUEUE_CORE_ASSERT_SVH
`define COMMAND_LINE_FRAMER_QUEUE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle, off while reset is high
`define CLFQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clfq check failed");

// antecedent implies consequent in the next cycle, off while reset is high
`define CLFQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clfq check failed");

// antecedent implies consequent in the next cycle, checked during reset too
`define CLFQ_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("clfq check failed");

`endif

/* rtl/clfq_pkg.sv */
`default_nettype none
package clfq_pkg;

   localparam int LINE_BYTES_DEF  = 64;
   localparam int QUEUE_SLOTS_DEF = 8;

   // opcodes
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_READ = 1'b1;

   // result status codes
   localparam logic [1:0] ST_CHAR      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_ZERO_LIM  = 2'd2;
   localparam logic [1:0] ST_NO_CHARS  = 2'd3;

   // special characters
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_HOLD   = 8'h21;
   localparam logic [7:0] CH_RESUME = 8'h7E;
   localparam logic [7:0] CH_CANCEL = 8'h18;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_value;
      logic       claimed_elsewhere;
      logic [6:0] read_limit;
   } req_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic        last;
      logic [1:0]  status;
      logic [31:0] overflow_total;
      logic [3:0]  free_slots;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/clfq_line_ram.sv */
`default_nettype none
module clfq_line_ram #(
   parameter int ADDR_W = 9
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire [ADDR_W-1:0] wr_addr,
   input  wire [7:0]        wr_data,
   input  wire              rd_en,
   input  wire [ADDR_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/command_line_framer_queue_core.sv */
// command line framer queue
// req channel: one transaction per operation. opcode feed passes one received
// byte (ignored when claimed_elsewhere is set); opcode read pops the oldest
// queued line. rsp channel: a read returns one transaction per character,
// at most read_limit-1 of them, the final one flagged by last. A zero limit,
// an empty queue or a line with nothing to deliver gives a single status
// transaction instead. A feed returns nothing.
// a feed is handled at acceptance, except an LF that closes a nonempty line,
// which copies the partial line into the queue slot through the line store
// write port one character at a time. A read streams one character per cycle
// out of the line store while rsp is not stalled, through the line store read
// register and the output register; a status result passes the status state
// and the output register. req_stall stays high while a copy or a read runs.
// rsp has an output register: a stalled result holds, and the read pauses
// until it is taken. Reset clears the queue, the partial line and the
// overflow count; no clearing pass is needed.
`default_nettype none
module command_line_framer_queue_core #(
   parameter int LINE_BYTES  = clfq_pkg::LINE_BYTES_DEF,
   parameter int QUEUE_SLOTS = clfq_pkg::QUEUE_SLOTS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  clfq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output clfq_pkg::rsp_type rsp_data
);

   localparam int LB_W   = $clog2(LINE_BYTES);
   localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
   localparam int HELD_W = $clog2(QUEUE_SLOTS + 1);
   localparam int ADDR_W = SLOT_W + LB_W;

   localparam logic [LB_W-1:0]   MAX_LEN   = LB_W'(LINE_BYTES - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
   localparam logic [HELD_W-1:0] ALL_HELD  = HELD_W'(QUEUE_SLOTS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_COPY   = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_STATUS = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [LB_W-1:0]   plen_ff, plen_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [31:0]       ovf_ff, ovf_in;
   logic [LB_W-1:0]   cnt_ff, cnt_in;
   logic [LB_W-1:0]   tot_ff, tot_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              pend_ff, pend_in;
   logic [LB_W-1:0]   pwidx_ff, pwidx_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   clfq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [LB_W-1:0] len_ff [QUEUE_SLOTS];
   logic [7:0]      pmem [LINE_BYTES];
   logic [7:0]      prd_ff;

   logic              len_we;
   logic [SLOT_W-1:0] len_widx;
   logic [LB_W-1:0]   len_wdata;
   logic              pm_we;
   logic              pm_re;
   logic              lr_we;
   logic [ADDR_W-1:0] lr_waddr;
   logic [7:0]        lr_wdata;
   logic              lr_re;
   logic [ADDR_W-1:0] lr_raddr;
   logic [7:0]        lr_rdata;

   logic              accept;
   logic              out_free;
   logic              issue;
   logic              is_rt;
   logic              room;
   logic [6:0]        lim_m1;
   logic [LB_W-1:0]   head_len;
   logic [LB_W-1:0]   n_chars;
   logic [31:0]       free_w;
   logic [SLOT_W-1:0] wslot_nxt;
   logic [SLOT_W-1:0] rslot_nxt;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_rt = (req_data.byte_value == clfq_pkg::CH_QUERY)
               || (req_data.byte_value == clfq_pkg::CH_HOLD)
               || (req_data.byte_value == clfq_pkg::CH_RESUME)
               || (req_data.byte_value == clfq_pkg::CH_CANCEL);
   assign room      = (held_ff < ALL_HELD);
   assign wslot_nxt = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + 1'b1;
   assign rslot_nxt = (rslot_ff == LAST_SLOT) ? '0 : rslot_ff + 1'b1;

   assign lim_m1   = req_data.read_limit - 7'd1;
   assign head_len = len_ff[rslot_ff];
   assign n_chars  = (lim_m1 < 7'(head_len)) ? LB_W'(lim_m1) : head_len;

   // free slot count after any pop, masked to the field width where it is used
   assign free_w = 32'(QUEUE_SLOTS) - 32'(held_ff);

   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      tot_in       = tot_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      pwidx_in     = pwidx_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      len_we       = 1'b0;
      len_widx     = wslot_ff;
      len_wdata    = LB_W'(1);
      pm_we        = 1'b0;
      pm_re        = 1'b0;
      lr_we        = 1'b0;
      lr_waddr     = {wslot_ff, LB_W'(0)};
      lr_wdata     = req_data.byte_value;
      lr_re        = 1'b0;
      lr_raddr     = {slot_ff, cnt_ff};
      issue        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.opcode == clfq_pkg::OP_FEED) begin
               if (!req_data.claimed_elsewhere) begin
                  if (is_rt) begin
                     if (room) begin
                        len_we   = 1'b1;
                        lr_we    = 1'b1;
                        wslot_in = wslot_nxt;
                        held_in  = held_ff + 1'b1;
                     end else begin
                        ovf_in = ovf_ff + 32'd1;
                     end
                  end else if (req_data.byte_value == clfq_pkg::CH_CR) begin
                     plen_in = plen_ff;
                  end else if (req_data.byte_value == clfq_pkg::CH_LF) begin
                     plen_in = '0;
                     if (plen_ff != '0) begin
                        if (room) begin
                           len_we    = 1'b1;
                           len_wdata = plen_ff;
                           slot_in   = wslot_ff;
                           tot_in    = plen_ff;
                           cnt_in    = '0;
                           pend_in   = 1'b0;
                           wslot_in  = wslot_nxt;
                           held_in   = held_ff + 1'b1;
                           state_in  = S_COPY;
                        end else begin
                           ovf_in = ovf_ff + 32'd1;
                        end
                     end
                  end else if (plen_ff < MAX_LEN) begin
                     pm_we   = 1'b1;
                     plen_in = plen_ff + 1'b1;
                  end else begin
                     // overlong line is thrown away together with this byte
                     plen_in = '0;
                  end
               end
            end else if (accept) begin
               if (req_data.read_limit == 7'd0) begin
                  status_in = clfq_pkg::ST_ZERO_LIM;
                  state_in  = S_STATUS;
               end else if (held_ff == '0) begin
                  status_in = clfq_pkg::ST_EMPTY;
                  state_in  = S_STATUS;
               end else begin
                  rslot_in = rslot_nxt;
                  held_in  = held_ff - 1'b1;
                  slot_in  = rslot_ff;
                  tot_in   = n_chars;
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  if (n_chars == '0) begin
                     status_in = clfq_pkg::ST_NO_CHARS;
                     state_in  = S_STATUS;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_COPY: begin
            // partial line read in the cycle before its line store write
            issue = (cnt_ff < tot_ff);
            if (issue) begin
               pm_re    = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               pwidx_in = cnt_ff;
            end
            pend_in = issue;
            if (pend_ff) begin
               lr_we    = 1'b1;
               lr_waddr = {slot_ff, pwidx_ff};
               lr_wdata = prd_ff;
            end
            if (!issue && !pend_ff) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            issue = (cnt_ff < tot_ff) && (!pend_ff || out_free);
            lr_re = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff && out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.char_out        = lr_rdata;
               rsp_data_in.last            = (cnt_ff == tot_ff);
               rsp_data_in.status          = clfq_pkg::ST_CHAR;
               rsp_data_in.overflow_total  = ovf_ff;
               rsp_data_in.free_slots      = free_w[3:0];
               if (cnt_ff == tot_ff) begin
                  state_in = S_IDLE;
               end
            end
            pend_in = issue || (pend_ff && !out_free);
         end
         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.char_out       = 8'd0;
               rsp_data_in.last           = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.overflow_total = ovf_ff;
               rsp_data_in.free_slots     = free_w[3:0];
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plen_ff      <= '0;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         held_ff      <= '0;
         ovf_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      tot_ff      <= tot_in;
      slot_ff     <= slot_in;
      pwidx_ff    <= pwidx_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_ff[len_widx] <= len_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[plen_ff] <= req_data.byte_value;
      end
      if (pm_re) begin
         prd_ff <= pmem[cnt_ff];
      end
   end

   clfq_line_ram #(
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (lr_we),
      .wr_addr (lr_waddr),
      .wr_data (lr_wdata),
      .rd_en   (lr_re),
      .rd_addr (lr_raddr),
      .rd_data (lr_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/clfq_checker.sv */
`default_nettype none
`include "command_line_framer_queue_core_assert.svh"
module clfq_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input clfq_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input clfq_pkg::rsp_type rsp_data
);

   logic req_seen;
   assign req_seen = req_valid && !req_stall && (req_data.opcode == clfq_pkg::OP_READ);

   // a stalled result stays put
   `CLFQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // any status other than a character ends the read
   `CLFQ_ASSERT_IMP(a_status_last, clock, reset, rsp_valid && rsp_data.status != clfq_pkg::ST_CHAR, rsp_data.last)

   // status transactions carry no character
   `CLFQ_ASSERT_IMP(a_status_char, clock, reset, rsp_valid && rsp_data.status != clfq_pkg::ST_CHAR, rsp_data.char_out == 8'd0)

   // reset leaves no result pending
   `CLFQ_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

   // an accepted read keeps the request side closed in the following cycle
   `CLFQ_ASSERT_NXT(a_read_busy, clock, reset, req_seen, req_stall)

endmodule

bind command_line_framer_queue_core clfq_checker u_clfq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
   import clfq_pkg::*;

   localparam int LINE_BYTES  = LINE_BYTES_DEF;
   localparam int QUEUE_SLOTS = QUEUE_SLOTS_DEF;

   // mirror of the line framer and its slot queue, plus the reads still owed
   class framer_mirror;
      logic [7:0]  partial_chars [LINE_BYTES];
      int unsigned partial_count;
      logic [7:0]  slot_chars [QUEUE_SLOTS][LINE_BYTES];
      int unsigned slot_count [QUEUE_SLOTS];
      int unsigned write_ptr;
      int unsigned read_ptr;
      int unsigned held;
      logic [31:0] dropped;
      rsp_type     owed_results [$];
      int          mismatches;

      function new();
         partial_count = 0;
         write_ptr     = 0;
         read_ptr      = 0;
         held          = 0;
         dropped       = '0;
         mismatches    = 0;
      endfunction

      // single: one real-time character, else the partial line
      function void push_line(bit single, logic [7:0] ch);
         int unsigned n;
         if (held < QUEUE_SLOTS) begin
            n = single ? 1 : partial_count;
            for (int i = 0; i < n; i++)
               slot_chars[write_ptr][i] = single ? ch : partial_chars[i];
            slot_count[write_ptr] = n;
            write_ptr = (write_ptr + 1) % QUEUE_SLOTS;
            held++;
         end else begin
            dropped++;
         end
      endfunction

      function void owe(logic [7:0] ch, logic last, logic [1:0] st);
         rsp_type r;
         r.char_out       = ch;
         r.last           = last;
         r.status         = st;
         r.overflow_total = dropped;
         r.free_slots     = 4'(QUEUE_SLOTS - held);
         owed_results.push_back(r);
      endfunction

      function void note_request(req_type q);
         int unsigned n;
         int unsigned slot;
         if (q.opcode == OP_FEED) begin
            if (!q.claimed_elsewhere) begin
               case (q.byte_value)
                  CH_QUERY, CH_HOLD, CH_RESUME, CH_CANCEL: push_line(1'b1, q.byte_value);
                  CH_CR: ;
                  CH_LF: begin
                     if (partial_count > 0) push_line(1'b0, 8'h00);
                     partial_count = 0;
                  end
                  default: begin
                     if (partial_count < LINE_BYTES - 1) begin
                        partial_chars[partial_count] = q.byte_value;
                        partial_count++;
                     end else begin
                        // overlong line is thrown away together with this byte
                        partial_count = 0;
                     end
                  end
               endcase
            end
         end else if (q.read_limit == 0) begin
            owe(8'h00, 1'b1, ST_ZERO_LIM);
         end else if (held == 0) begin
            owe(8'h00, 1'b1, ST_EMPTY);
         end else begin
            slot = read_ptr;
            n = q.read_limit - 1;
            if (n > slot_count[slot]) n = slot_count[slot];
            read_ptr = (read_ptr + 1) % QUEUE_SLOTS;
            held--;
            if (n == 0) owe(8'h00, 1'b1, ST_NO_CHARS);
            else
               for (int i = 0; i < n; i++)
                  owe(slot_chars[slot][i], (i == n - 1), ST_CHAR);
         end
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: response with nothing owed, expected none actual %p", $time, got);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         compare("char_out", 32'(want.char_out), 32'(got.char_out));
         compare("last", 32'(want.last), 32'(got.last));
         compare("status", 32'(want.status), 32'(got.status));
         compare("overflow_total", want.overflow_total, got.overflow_total);
         compare("free_slots", 32'(want.free_slots), 32'(got.free_slots));
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   framer_mirror mirror;
   bit           quiet    = 1'b0;
   int           rsp_hold = 0;
   int           sent     = 0;

   command_line_framer_queue_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // responses first, so a stray one is never matched to a fresh read
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) mirror.check_response(rsp_data);
         if (req_valid && !req_stall) mirror.note_request(req_data);
      end
   end

   // receiver holds off a random number of cycles after each transaction
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_hold = quiet ? 0 : $urandom_range(0, 15);
      else if (rsp_hold > 0) rsp_hold--;
      rsp_stall <= (rsp_hold > 0);
   end

   task automatic send(input logic op, input logic [7:0] b, input logic claimed,
                       input logic [6:0] lim);
      req_type item;
      int      gap;
      item.opcode            = op;
      item.byte_value        = b;
      item.claimed_elsewhere = claimed;
      item.read_limit        = lim;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic feed(input logic [7:0] b);
      send(OP_FEED, b, 1'b0, 7'($urandom));
   endtask

   task automatic read_line(input logic [6:0] lim);
      send(OP_READ, 8'($urandom), 1'($urandom), lim);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CH_QUERY || b == CH_HOLD || b == CH_RESUME || b == CH_CANCEL ||
             b == CH_CR || b == CH_LF);
      return b;
   endfunction

   task automatic feed_text(input int n, input bit with_cr);
      for (int i = 0; i < n; i++) feed(text_byte());
      if (with_cr) feed(CH_CR);
      feed(CH_LF);
   endtask

   function automatic logic [7:0] realtime_char();
      case ($urandom_range(0, 3))
         0: return CH_QUERY;
         1: return CH_HOLD;
         2: return CH_RESUME;
         default: return CH_CANCEL;
      endcase
   endfunction

   // step the clock first so the monitor has noted the last accepted transaction
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.owed_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [6:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'($urandom);
         3: return 7'd64;
         default: return 7'($urandom_range(2, 20));
      endcase
   endfunction

   initial begin
      int kind;
      mirror = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      read_line(7'd5);
      read_line(7'd0);
      send(OP_FEED, 8'h41, 1'b1, 7'd0);
      feed(8'h00);
      feed(8'hFF);
      feed(CH_CR);
      feed(CH_LF);
      feed(CH_LF);
      feed(CH_QUERY);
      feed(CH_HOLD);
      feed(CH_RESUME);
      feed(CH_CANCEL);
      read_line(7'd64);
      read_line(7'd1);
      read_line(7'd2);
      read_line(7'd127);
      read_line(7'd3);
      read_line(7'd64);
      drain();

      // longest line, then a line that runs past the partial buffer
      feed_text(LINE_BYTES - 1, 1'b0);
      read_line(7'd64);
      feed_text(LINE_BYTES + 6, 1'b1);
      read_line(7'd127);
      // more lines than slots
      for (int i = 0; i < QUEUE_SLOTS + 3; i++) feed(realtime_char());
      for (int i = 0; i < QUEUE_SLOTS + 1; i++) read_line(pick_limit());

      while (sent < 300) begin
         kind = $urandom_range(0, 99);
         if (kind < 3) feed_text($urandom_range(55, 70), 1'($urandom));
         else if (kind < 40) feed_text($urandom_range(1, 12), 1'($urandom));
         else if (kind < 52) feed(realtime_char());
         else if (kind < 78) read_line(pick_limit());
         else if (kind < 88) send(OP_FEED, 8'($urandom), 1'($urandom), 7'($urandom));
         else if (kind < 94) begin
            // broken line: some text, then a read or a stray terminator
            for (int i = $urandom_range(1, 5); i > 0; i--) feed(text_byte());
            if ($urandom_range(0, 1)) read_line(pick_limit());
            else feed($urandom_range(0, 1) ? CH_CR : CH_LF);
         end else if (kind < 98) quiet = ($urandom_range(0, 2) == 0);
         else drain();
      end
      drain();
      repeat (100) @(posedge clock);

      if (mirror.owed_results.size() != 0) begin
         $display("%0t: responses never arrived, expected %0d actual 0", $time,
                  mirror.owed_results.size());
         mirror.mismatches++;
      end
      if (mirror.mismatches == 0) begin
         $display("command_line_framer_queue_core regression: pass");
      end else begin
         $display("command_line_framer_queue_core regression: fail");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("command_line_framer_queue_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
